// ===== src/ethernet_ipv4_header_parser_defines.svh =====
// ----------------------------------------------------------------------------
// Ethernet IPv4 header parser assertion macros
// Shared concurrent assertion forms used by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_IPV4_HEADER_PARSER_DEFINES_SVH
`define ETHERNET_IPV4_HEADER_PARSER_DEFINES_SVH

// Checks a consequence in the same cycle as its antecedent.
`define EIHP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define EIHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/eihp_pkg.sv =====
// ----------------------------------------------------------------------------
// Ethernet IPv4 header parser package
// Widths, header constants, status codes and shared structures.
// ----------------------------------------------------------------------------
package eihp_pkg;

  localparam int COUNT_W   = 14;
  localparam int CFG_IDX_W = 4;

  localparam logic [COUNT_W-1:0] MAX_FRAME_LEN = COUNT_W'(16383);
  localparam logic [COUNT_W-1:0] ETH_HDR_LEN   = COUNT_W'(14);
  localparam logic [COUNT_W-1:0] IP_MIN_LEN    = COUNT_W'(20);
  localparam logic [COUNT_W-1:0] TCP_HDR_LEN   = COUNT_W'(20);
  localparam logic [COUNT_W-1:0] UDP_HDR_LEN   = COUNT_W'(8);
  localparam logic [COUNT_W-1:0] ICMP_HDR_LEN  = COUNT_W'(8);

  localparam logic [COUNT_W-1:0] POS_TYPE_HI = COUNT_W'(12);
  localparam logic [COUNT_W-1:0] POS_TYPE_LO = COUNT_W'(13);
  localparam logic [COUNT_W-1:0] POS_IHL     = COUNT_W'(14);
  localparam logic [COUNT_W-1:0] POS_PROTO   = COUNT_W'(23);
  localparam logic [COUNT_W-1:0] POS_SRC_LO  = COUNT_W'(26);
  localparam logic [COUNT_W-1:0] POS_SRC_HI  = COUNT_W'(29);
  localparam logic [COUNT_W-1:0] POS_DST_LO  = COUNT_W'(30);
  localparam logic [COUNT_W-1:0] POS_DST_HI  = COUNT_W'(33);

  localparam logic [15:0] ETHTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP   = 8'd1;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [3:0]  IHL_MIN      = 4'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TRUNC   = 2'd1;
  localparam logic [1:0] ST_BAD_IHL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ON   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_TCP  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_UDP  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_ICMP = CFG_IDX_W'(3);

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [15:0]        ether_type;
    logic [3:0]         ihl;
    logic [7:0]         proto;
    logic [31:0]        ip_saddr;
    logic [31:0]        ip_daddr;
    logic [15:0]        l4_sport;
    logic [15:0]        l4_dport;
  } frame_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               is_ipv4;
    logic               pass_filter;
    logic [15:0]        ether_type;
    logic [7:0]         ip_proto;
    logic [31:0]        source_addr;
    logic [31:0]        dest_addr;
    logic [15:0]        source_port;
    logic [15:0]        dest_port;
    logic [COUNT_W-1:0] frame_length;
  } result_t;

endpackage

// ===== src/eihp_in_if.sv =====
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel carrying one frame byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface eihp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== src/eihp_out_if.sv =====
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one parsed header result per frame.
// ----------------------------------------------------------------------------
interface eihp_out_if import eihp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               is_ipv4;
  logic               pass_filter;
  logic [15:0]        ether_type;
  logic [7:0]         ip_proto;
  logic [31:0]        source_addr;
  logic [31:0]        dest_addr;
  logic [15:0]        source_port;
  logic [15:0]        dest_port;
  logic [COUNT_W-1:0] frame_length;

  modport source (output valid, output status, output is_ipv4, output pass_filter,
                  output ether_type, output ip_proto, output source_addr,
                  output dest_addr, output source_port, output dest_port,
                  output frame_length, input ready);
  modport sink   (input valid, input status, input is_ipv4, input pass_filter,
                  input ether_type, input ip_proto, input source_addr,
                  input dest_addr, input source_port, input dest_port,
                  input frame_length, output ready);
endinterface

// ===== src/eihp_capture.sv =====
// ----------------------------------------------------------------------------
// Header field capture
// Counts frame bytes and captures header fields by byte position.
// ----------------------------------------------------------------------------
module eihp_capture import eihp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] frame_byte,
  input  logic       last_byte,
  output frame_t     frame_nxt
);

  frame_t             frame_r;
  logic [COUNT_W-1:0] pos;
  logic [COUNT_W-1:0] tport;

  always_comb begin
    pos       = frame_r.count;
    tport     = ETH_HDR_LEN + COUNT_W'({frame_r.ihl, 2'b00});
    frame_nxt = frame_r;
    if (pos < MAX_FRAME_LEN) begin
      if (pos == POS_TYPE_HI || pos == POS_TYPE_LO) begin
        frame_nxt.ether_type = {frame_r.ether_type[7:0], frame_byte};
      end
      if (pos == POS_IHL) begin
        frame_nxt.ihl = frame_byte[3:0];
      end
      if (pos == POS_PROTO) begin
        frame_nxt.proto = frame_byte;
      end
      if (pos >= POS_SRC_LO && pos <= POS_SRC_HI) begin
        frame_nxt.ip_saddr = {frame_r.ip_saddr[23:0], frame_byte};
      end
      if (pos >= POS_DST_LO && pos <= POS_DST_HI) begin
        frame_nxt.ip_daddr = {frame_r.ip_daddr[23:0], frame_byte};
      end
      if (pos > POS_IHL && frame_r.ihl >= IHL_MIN) begin
        if (pos == tport || pos == tport + COUNT_W'(1)) begin
          frame_nxt.l4_sport = {frame_r.l4_sport[7:0], frame_byte};
        end
        if (pos == tport + COUNT_W'(2) || pos == tport + COUNT_W'(3)) begin
          frame_nxt.l4_dport = {frame_r.l4_dport[7:0], frame_byte};
        end
      end
      frame_nxt.count = pos + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
    end else if (step) begin
      frame_r <= last_byte ? '0 : frame_nxt;
    end
  end

endmodule

// ===== src/ethernet_ipv4_header_parser.sv =====
// ----------------------------------------------------------------------------
// Ethernet IPv4 header parser
// Parses Ethernet, IPv4 and TCP/UDP headers from a byte stream and gives
// one result with status, fields and a filter verdict per frame.
// ----------------------------------------------------------------------------
//   Channel   Direction  Moves
//   in_ch     sink       one frame byte and last-byte mark per request
//   out_ch    source     one parsed header result per frame
//   cfg_*     write      filter_on, accept_tcp, accept_udp, accept_icmp
//
// One byte is taken every cycle unless the input stalls; each byte passes
// an input register and is captured as it leaves it. A frame's result is
// put in the output register as the last byte leaves the input register.
// The input stalls only while a last byte waits on a full output register.
// Synchronous reset clears the frame state, configuration and valid flags.
// ----------------------------------------------------------------------------
`include "ethernet_ipv4_header_parser_defines.svh"

module ethernet_ipv4_header_parser import eihp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  eihp_in_if.sink              in_ch,
  eihp_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata
);

  logic       filter_on_r, accept_tcp_r, accept_udp_r, accept_icmp_r;
  logic       s1_valid_r, s1_last_r;
  logic [7:0] s1_byte_r;
  logic       s1_adv;
  logic       out_valid_r;
  result_t    out_data_r;
  result_t    res_nxt;
  frame_t     frame_nxt;

  logic [COUNT_W-1:0] len;
  logic [COUNT_W-1:0] tport;
  logic [COUNT_W-1:0] need;

  assign s1_adv      = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  eihp_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .frame_byte (s1_byte_r),
    .last_byte  (s1_last_r),
    .frame_nxt  (frame_nxt)
  );

  always_comb begin
    len     = frame_nxt.count;
    tport   = ETH_HDR_LEN + COUNT_W'({frame_nxt.ihl, 2'b00});
    need    = (frame_nxt.proto == PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN;
    res_nxt = '0;
    res_nxt.frame_length = len;
    if (len < ETH_HDR_LEN) begin
      res_nxt.status = ST_TRUNC;
    end else begin
      res_nxt.ether_type = frame_nxt.ether_type;
      res_nxt.is_ipv4    = (frame_nxt.ether_type == ETHTYPE_IPV4);
      if (res_nxt.is_ipv4) begin
        if (len < ETH_HDR_LEN + IP_MIN_LEN) begin
          res_nxt.status = ST_TRUNC;
        end else if (frame_nxt.ihl < IHL_MIN) begin
          res_nxt.status = ST_BAD_IHL;
        end else if (len < tport) begin
          res_nxt.status = ST_TRUNC;
        end else begin
          res_nxt.ip_proto    = frame_nxt.proto;
          res_nxt.source_addr = frame_nxt.ip_saddr;
          res_nxt.dest_addr   = frame_nxt.ip_daddr;
          if (frame_nxt.proto == PROTO_TCP || frame_nxt.proto == PROTO_UDP) begin
            if (len < tport + need) begin
              res_nxt.status = ST_TRUNC;
            end else begin
              res_nxt.source_port = frame_nxt.l4_sport;
              res_nxt.dest_port   = frame_nxt.l4_dport;
            end
          end else if (frame_nxt.proto == PROTO_ICMP) begin
            if (len < tport + ICMP_HDR_LEN) begin
              res_nxt.status = ST_TRUNC;
            end
          end
        end
      end
    end
    if (res_nxt.status == ST_OK) begin
      res_nxt.pass_filter = !filter_on_r ||
        (res_nxt.is_ipv4 &&
         ((res_nxt.ip_proto == PROTO_TCP  && accept_tcp_r) ||
          (res_nxt.ip_proto == PROTO_UDP  && accept_udp_r) ||
          (res_nxt.ip_proto == PROTO_ICMP && accept_icmp_r)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_on_r   <= 1'b0;
      accept_tcp_r  <= 1'b0;
      accept_udp_r  <= 1'b0;
      accept_icmp_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER_ON:   filter_on_r   <= cfg_wdata;
        REG_ACCEPT_TCP:  accept_tcp_r  <= cfg_wdata;
        REG_ACCEPT_UDP:  accept_udp_r  <= cfg_wdata;
        REG_ACCEPT_ICMP: accept_icmp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.frame_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_data_r.status;
  assign out_ch.is_ipv4      = out_data_r.is_ipv4;
  assign out_ch.pass_filter  = out_data_r.pass_filter;
  assign out_ch.ether_type   = out_data_r.ether_type;
  assign out_ch.ip_proto     = out_data_r.ip_proto;
  assign out_ch.source_addr  = out_data_r.source_addr;
  assign out_ch.dest_addr    = out_data_r.dest_addr;
  assign out_ch.source_port  = out_data_r.source_port;
  assign out_ch.dest_port    = out_data_r.dest_port;
  assign out_ch.frame_length = out_data_r.frame_length;

  `EIHP_ASSERT_SAME(a_err_no_pass, out_valid_r && out_data_r.status != ST_OK, !out_data_r.pass_filter, "error result passes filter")
  `EIHP_ASSERT_SAME(a_non_ipv4_zero, out_valid_r && !out_data_r.is_ipv4, out_data_r.ip_proto == 8'd0 && out_data_r.source_addr == 32'd0, "non-IPv4 result carries IPv4 fields")
  `EIHP_ASSERT_SAME(a_ports_l4, out_valid_r && (out_data_r.source_port != 16'd0 || out_data_r.dest_port != 16'd0), out_data_r.ip_proto == PROTO_TCP || out_data_r.ip_proto == PROTO_UDP, "ports reported without TCP or UDP")
  `EIHP_ASSERT_NEXT(a_last_gives_result, s1_adv && s1_last_r, out_valid_r, "last byte produced no result")
  `EIHP_ASSERT_SAME(a_len_nonzero, out_valid_r, out_data_r.frame_length != '0, "result with zero frame length")

endmodule
